>>> design/chq_pkg.sv
// ----------------------------------------------------------------------------
// chq_pkg
// shared types, codes and saturation helpers for the chiral quad force unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PRD,
    S_PCAP,
    S_BOND,
    S_CROSS,
    S_TRIP,
    S_CHIR,
    S_SQ,
    S_EN,
    S_DE,
    S_F,
    S_FRD,
    S_FCAP,
    S_FMUL,
    S_FWR,
    S_RRD,
    S_RCAP
  } state_e;

  // post-product right shift
  typedef enum logic [1:0] {
    SH16,
    SH17,
    SH24,
    SH32
  } sh_e;

  // result saturation width
  typedef enum logic {
    SAT48,
    SAT62
  } sat_e;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    sh_e                sh;
    sat_e               sat;
  } mul_req_t;

  localparam logic signed [63:0] Max48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Min48 = 64'shFFFF_8000_0000_0000;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > Max48) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < Min48) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 33'sh1_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // (j+1) mod 3
  function automatic logic [1:0] nxt1(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // (j+2) mod 3
  function automatic logic [1:0] nxt2(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> design/chq_ram.sv
// ----------------------------------------------------------------------------
// chq_ram
// simple dual-port synchronous memory, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/chq_mul.sv
// ----------------------------------------------------------------------------
// chq_mul
// signed 64x64 multiply, truncate toward zero, shift and saturate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chq_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  chq_pkg::mul_req_t  req_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);
  import chq_pkg::*;

  logic         busy_q, fin_q, done_q;
  logic [1:0]   cnt_q;
  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  sh_e          sh_q;
  sat_e         sat_q;
  logic [127:0] acc_q;
  logic signed [63:0] res_q;

  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] shifted;
  logic [63:0]  lim, mag;

  // one 32x32 partial product per cycle, low/high halves picked by the count
  assign op_a = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
  assign op_b = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
  assign pp   = op_a * op_b;

  always_comb begin
    unique case (cnt_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  always_comb begin
    unique case (sh_q)
      SH16:    shifted = acc_q >> 16;
      SH17:    shifted = acc_q >> 17;
      SH24:    shifted = acc_q >> 24;
      default: shifted = acc_q >> 32;
    endcase
    lim = ((sat_q == SAT62) ? 64'h1FFF_FFFF_FFFF_FFFF : 64'h0000_7FFF_FFFF_FFFF)
          + 64'(neg_q);
    mag = (shifted > 128'(lim)) ? lim : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= req_i.a[63] ? (~req_i.a + 64'd1) : req_i.a;
      ub_q  <= req_i.b[63] ? (~req_i.b + 64'd1) : req_i.b;
      neg_q <= req_i.a[63] ^ req_i.b[63];
      sh_q  <= req_i.sh;
      sat_q <= req_i.sat;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end else if (fin_q) begin
      res_q <= neg_q ? (64'd0 - mag) : mag;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/chiral_quad_force_top.sv
// ----------------------------------------------------------------------------
// chiral_quad_force_top
// load / read: accepted in idle; a force read beat passes S_RRD and S_RCAP into
//   the output register; clear energy acts on the accept beat; quad: runs its
//   38 products through the single shared 32x32 multiplier, plus 4
//   position reads and 4 force read-modify-writes through registered-read memories
// one item at a time; async active-low reset clears control, energy and the
//   strength register (1.0), the position and force memories stay unset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chiral_quad_force_top #(
  parameter int ATOM_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [9:0]         atom_a_i,
  input  logic [9:0]         atom_b_i,
  input  logic [9:0]         atom_c_i,
  input  logic [9:0]         atom_d_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        native_factor_i,
  input  logic signed [31:0] native_chirality_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] force_x_o,
  output logic signed [47:0] force_y_o,
  output logic signed [47:0] force_z_o,
  output logic signed [47:0] energy_o,
  // strength register write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import chq_pkg::*;

  localparam int AW = $clog2(ATOM_COUNT);

  // atom index wrap modulo ATOM_COUNT: restoring reduction, eight steps
  function automatic logic [9:0] wrap_idx(input logic [9:0] v);
    logic [26:0] t;
    t = 27'(v);
    for (int k = 7; k >= 0; k--) begin
      if (t >= (27'(ATOM_COUNT) << k)) begin
        t = t - (27'(ATOM_COUNT) << k);
      end
    end
    return t[9:0];
  endfunction

  state_e state_q, state_d;

  logic in_fire;
  logic mul_state, mul_start, mul_done, mul_pend_q, mul_done_raw;
  mul_req_t mul_req;
  logic signed [63:0] mul_res;

  // captured item
  logic [AW-1:0]      idx_q [4];
  logic [31:0]        nf_q;
  logic signed [31:0] nchir_q;
  logic [31:0]        strength_q;

  // sequencing counters
  logic [1:0] pk_q, atom_q, cross_q, comp_q;
  logic       term_q;

  // quad working set
  logic signed [31:0] p_q [4][3];   // positions a..d
  logic signed [31:0] r_q [3][3];   // r12, r23, r34
  logic signed [48:0] x_q [3][3];   // x12_23, x12_34, x23_34
  logic signed [63:0] trip_q;
  logic signed [47:0] diff_q, sq_q, f_q;
  logic signed [47:0] energy_q;
  logic signed [47:0] facc_q [3];   // force entry under update

  // output register
  logic               out_valid_q;
  logic signed [47:0] fx_q, fy_q, fz_q, en_q;

  // memory ports
  logic          pos_we, pos_re, frc_we, frc_re;
  logic [AW-1:0] pos_waddr, pos_raddr, frc_waddr, frc_raddr;
  logic [95:0]   pos_wdata, pos_rdata;
  logic [143:0]  frc_wdata, frc_rdata;

  logic [1:0] cu, cv, i1, i2;
  logic signed [49:0] fvec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign mul_done    = mul_done_raw && mul_pend_q;
  // strength only changes while no quad is in flight
  assign cfg_ready_o = (state_q == S_IDLE);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(op_i))
            OP_QUAD: state_d = S_PRD;
            OP_READ: state_d = S_RRD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PRD:   state_d = S_PCAP;
      S_PCAP:  state_d = (pk_q == 2'd3) ? S_BOND : S_PRD;
      S_BOND:  state_d = S_CROSS;
      S_CROSS: begin
        if (mul_done && cross_q == 2'd2 && comp_q == 2'd2 && term_q) begin
          state_d = S_TRIP;
        end
      end
      S_TRIP:  if (mul_done && comp_q == 2'd2) state_d = S_CHIR;
      S_CHIR:  if (mul_done) state_d = S_SQ;
      S_SQ:    if (mul_done) state_d = S_EN;
      S_EN:    if (mul_done) state_d = S_DE;
      S_DE:    if (mul_done) state_d = S_F;
      S_F:     if (mul_done) state_d = S_FRD;
      S_FRD:   state_d = S_FCAP;
      S_FCAP:  state_d = S_FMUL;
      S_FMUL:  if (mul_done && comp_q == 2'd2) state_d = S_FWR;
      S_FWR:   state_d = (atom_q == 2'd3) ? S_IDLE : S_FRD;
      S_RRD:   state_d = S_RCAP;
      S_RCAP:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // control outputs: memory ports, multiplier requests
  // --------------------------------------------------------------------------
  always_comb begin
    cu = (cross_q == 2'd2) ? 2'd1 : 2'd0;
    cv = (cross_q == 2'd0) ? 2'd1 : 2'd2;
    i1 = nxt1(comp_q);
    i2 = nxt2(comp_q);

    // force direction vector for the atom in hand
    unique case (atom_q)
      2'd0:    fvec = 50'(x_q[2][comp_q]);
      2'd1:    fvec = 50'(x_q[1][comp_q]) + 50'(x_q[2][comp_q]);
      2'd2:    fvec = 50'(x_q[0][comp_q]) + 50'(x_q[1][comp_q]);
      default: fvec = 50'(x_q[0][comp_q]);
    endcase

    // loads write the position and zero the force on the accept beat
    pos_we    = in_fire && (op_e'(op_i) == OP_LOAD);
    pos_waddr = AW'(wrap_idx(atom_a_i));
    pos_wdata = {pos_z_i, pos_y_i, pos_x_i};
    pos_re    = (state_q == S_PRD);
    pos_raddr = idx_q[pk_q];

    frc_we    = pos_we || (state_q == S_FWR);
    frc_waddr = (state_q == S_FWR) ? idx_q[atom_q] : pos_waddr;
    frc_wdata = (state_q == S_FWR) ? {facc_q[2], facc_q[1], facc_q[0]} : '0;
    frc_re    = (state_q == S_FRD) || (state_q == S_RRD);
    frc_raddr = (state_q == S_FRD) ? idx_q[atom_q] : idx_q[0];

    mul_req.a   = '0;
    mul_req.b   = '0;
    mul_req.sh  = SH16;
    mul_req.sat = SAT48;
    mul_state   = 1'b1;
    unique case (state_q)
      S_CROSS: begin
        mul_req.a = term_q ? 64'(r_q[cu][i2]) : 64'(r_q[cu][i1]);
        mul_req.b = term_q ? 64'(r_q[cv][i1]) : 64'(r_q[cv][i2]);
      end
      S_TRIP: begin
        mul_req.a   = 64'(r_q[0][comp_q]);
        mul_req.b   = 64'(x_q[2][comp_q]);
        mul_req.sat = SAT62;
      end
      S_CHIR: begin
        mul_req.a  = trip_q;
        mul_req.b  = $signed(64'(nf_q));
        mul_req.sh = SH24;
      end
      S_SQ: begin
        mul_req.a  = 64'(diff_q);
        mul_req.b  = 64'(diff_q);
        mul_req.sh = SH24;
      end
      S_EN: begin
        mul_req.a  = 64'(sq_q);
        mul_req.b  = $signed(64'(strength_q));
        mul_req.sh = SH17;
      end
      S_DE: begin
        mul_req.a = 64'(diff_q);
        mul_req.b = $signed(64'(strength_q));
      end
      S_F: begin
        mul_req.a  = 64'(f_q);
        mul_req.b  = $signed(64'(nf_q));
        mul_req.sh = SH32;
      end
      S_FMUL: begin
        mul_req.a = 64'(f_q);
        mul_req.b = 64'(fvec);
      end
      default: mul_state = 1'b0;
    endcase
    mul_start = mul_state && !mul_pend_q;
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_pend_q  <= 1'b0;
      pk_q        <= '0;
      atom_q      <= '0;
      cross_q     <= '0;
      comp_q      <= '0;
      term_q      <= 1'b0;
      energy_q    <= '0;
      strength_q  <= 32'h0001_0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (mul_start) begin
        mul_pend_q <= 1'b1;
      end else if (mul_done) begin
        mul_pend_q <= 1'b0;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        strength_q <= cfg_data_i;
      end

      if (in_fire) begin
        pk_q    <= '0;
        atom_q  <= '0;
        cross_q <= '0;
        comp_q  <= '0;
        term_q  <= 1'b0;
        if (op_e'(op_i) == OP_CLEAR) begin
          energy_q <= '0;
        end
      end

      if (state_q == S_PCAP) begin
        pk_q <= pk_q + 2'd1;
      end

      // cross products walk term, then component, then pair
      if (state_q == S_CROSS && mul_done) begin
        term_q <= !term_q;
        if (term_q) begin
          comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            cross_q <= cross_q + 2'd1;
          end
        end
      end

      if ((state_q == S_TRIP || state_q == S_FMUL) && mul_done) begin
        comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
      end

      if (state_q == S_EN && mul_done) begin
        energy_q <= sat48(64'(energy_q) + mul_res);
      end

      if (state_q == S_FWR) begin
        atom_q <= atom_q + 2'd1;
      end

      // a new beat may replace the one leaving on the same edge
      if (state_q == S_RCAP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q[0] <= AW'(wrap_idx(atom_a_i));
      idx_q[1] <= AW'(wrap_idx(atom_b_i));
      idx_q[2] <= AW'(wrap_idx(atom_c_i));
      idx_q[3] <= AW'(wrap_idx(atom_d_i));
      nf_q     <= native_factor_i;
      nchir_q  <= native_chirality_i;
    end

    if (state_q == S_PCAP) begin
      p_q[pk_q][0] <= pos_rdata[31:0];
      p_q[pk_q][1] <= pos_rdata[63:32];
      p_q[pk_q][2] <= pos_rdata[95:64];
    end

    // bond vectors, clamped to Q16.16
    if (state_q == S_BOND) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          r_q[k][c] <= clamp32(33'(p_q[k+1][c]) - 33'(p_q[k][c]));
        end
      end
      trip_q <= '0;
    end

    if (state_q == S_CROSS && mul_done) begin
      if (!term_q) begin
        x_q[cross_q][comp_q] <= 49'(mul_res);
      end else begin
        x_q[cross_q][comp_q] <= x_q[cross_q][comp_q] - 49'(mul_res);
      end
    end

    if (state_q == S_TRIP && mul_done) begin
      trip_q <= trip_q + mul_res;
    end

    if (state_q == S_CHIR && mul_done) begin
      diff_q <= sat48(mul_res - 64'(nchir_q));
    end

    if (state_q == S_SQ && mul_done) begin
      sq_q <= mul_res[47:0];
    end

    if ((state_q == S_DE || state_q == S_F) && mul_done) begin
      f_q <= mul_res[47:0];
    end

    if (state_q == S_FCAP) begin
      facc_q[0] <= frc_rdata[47:0];
      facc_q[1] <= frc_rdata[95:48];
      facc_q[2] <= frc_rdata[143:96];
    end

    // atoms b and d take the negated term
    if (state_q == S_FMUL && mul_done) begin
      if (atom_q[0]) begin
        facc_q[comp_q] <= sat48(64'(facc_q[comp_q]) - mul_res);
      end else begin
        facc_q[comp_q] <= sat48(64'(facc_q[comp_q]) + mul_res);
      end
    end

    if (state_q == S_RCAP && (!out_valid_q || out_ready_i)) begin
      fx_q <= frc_rdata[47:0];
      fy_q <= frc_rdata[95:48];
      fz_q <= frc_rdata[143:96];
      en_q <= energy_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign force_z_o   = fz_q;
  assign energy_o    = en_q;

  // --------------------------------------------------------------------------
  // units
  // --------------------------------------------------------------------------
  chq_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .req_i   (mul_req),
    .done_o  (mul_done_raw),
    .res_o   (mul_res)
  );

  // positions {z, y, x}, Q16.16
  chq_ram #(
    .WIDTH (96),
    .DEPTH (ATOM_COUNT)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // force sums {z, y, x}, Q24.24
  chq_ram #(
    .WIDTH (144),
    .DEPTH (ATOM_COUNT)
  ) u_frc_ram (
    .clk_i   (clk_i),
    .we_i    (frc_we),
    .waddr_i (frc_waddr),
    .wdata_i (frc_wdata),
    .re_i    (frc_re),
    .raddr_i (frc_raddr),
    .rdata_o (frc_rdata)
  );

endmodule

>>> design/chq_checker.sv
// ----------------------------------------------------------------------------
// chq_props
// port-level checks on the chiral quad force unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chq_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         op_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [47:0] force_x_o,
  input logic signed [47:0] energy_o
);
  import chq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(force_x_o) && $stable(energy_o))
    else $error("stalled result beat changed");

  // a result only appears after the unit has been busy
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a read in flight");

  // a quad occupies the unit
  a_quad_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_QUAD |=> !in_ready_o)
    else $error("item accepted during quad");

  // a force read keeps the unit busy through S_RRD and S_RCAP
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_READ |=> !in_ready_o ##1 !in_ready_o)
    else $error("item accepted during force read");

endmodule

bind chiral_quad_force_top chq_props u_chq_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .force_x_o   (force_x_o),
  .energy_o    (energy_o)
);
